@@ sv/json_string_escaper_utf8_assert.svh @@
// Assertion helpers for the string escaper; clk and rst_n come from the including scope.
`ifndef JSON_STRING_ESCAPER_UTF8_ASSERT_SVH
`define JSON_STRING_ESCAPER_UTF8_ASSERT_SVH

// same-cycle implication
`define JSE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define JSE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/jse_pkg.sv @@
`default_nettype none

package jse_pkg;

    // what follows the held-byte part of a command
    typedef logic [2:0] tail_kind_t;
    localparam tail_kind_t TAIL_NONE  = 3'd0;
    localparam tail_kind_t TAIL_RAW   = 3'd1;
    localparam tail_kind_t TAIL_SHORT = 3'd2;
    localparam tail_kind_t TAIL_HEX   = 3'd3;
    localparam tail_kind_t TAIL_CLOSE = 3'd4;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_ZERO   = 8'h30;

    // at most one command per item: optional opening quote, held bytes (raw or
    // escaped), then a tail action
    typedef struct packed {
        logic             open;
        logic [1:0]       pend_cnt;
        logic             pend_raw;
        logic [2:0][7:0]  pend;
        tail_kind_t       tail;
        logic [7:0]       fresh;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

`default_nettype wire

@@ sv/jse_in_if.sv @@
`default_nettype none

interface jse_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       end_of_string;

    modport source (output valid, output byte_value, output end_of_string, input ready);
    modport sink   (input valid, input byte_value, input end_of_string, output ready);
endinterface

`default_nettype wire

@@ sv/jse_out_if.sv @@
`default_nettype none

interface jse_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;

    modport source (output valid, output out_byte, output last_of_run, input ready);
    modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

`default_nettype wire

@@ sv/json_string_escaper_utf8.sv @@
// JSON string escaper with UTF-8 checking.
// raw (valid/ready): one string byte per item, or an end item
//   (end_of_string = 1, byte_value ignored) that closes the string.
// quoted (valid/ready): the quoted text, one byte per item; last_of_run marks
//   the final output byte caused by one raw item.
// The front classifies each raw item and tracks held UTF-8 bytes; it takes
//   one item per cycle while the command queue (QUEUE_DEPTH entries) has room.
//   Items that only extend a held sequence produce nothing and use no slot.
// The back expands one command at a time, one output byte per cycle while
//   quoted.ready is high: escapes cost 2 or 6 bytes, so sustained input
//   rate is set by the output byte count of each item.
// Path: an item's command is written into the queue, and its first output
//   byte is then loaded into the output register.
// Stall: when quoted.ready is low the output register holds; the queue fills
//   and raw.ready drops once QUEUE_DEPTH commands wait.
// Reset: queue empty, nothing held, the next item opens a new string.
`default_nettype none
`include "json_string_escaper_utf8_assert.svh"

module json_string_escaper_utf8
    import jse_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    jse_in_if.sink    raw,
    jse_out_if.source quoted
);

    cmd_t    f_cmd;
    cmd_t    q_head;
    q_stat_t q_stat;
    logic    q_push;
    logic    b_pop;

    // classification and held-byte tracking
    jse_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .raw    (raw),
        .q_stat (q_stat),
        .push   (q_push),
        .cmd    (f_cmd)
    );

    // decouples acceptance from expansion
    jse_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .wr_cmd (f_cmd),
        .pop    (b_pop),
        .head   (q_head),
        .stat   (q_stat)
    );

    // byte sequencer with output register
    jse_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (q_head),
        .q_stat (q_stat),
        .pop    (b_pop),
        .quoted (quoted)
    );

    // every end item yields at least the closing quote
    `JSE_ASSERT_NOW(a_end_pushes, raw.valid && raw.ready && raw.end_of_string, q_push, "end item not queued")
    // a command retires exactly when its last byte is loaded
    `JSE_ASSERT_NEXT(a_pop_last, b_pop, quoted.valid && quoted.last_of_run, "pop without last byte")
    `JSE_ASSERT_NOW(a_no_pop_empty, q_stat.empty, !b_pop, "pop from empty queue")
    `JSE_ASSERT_NOW(a_no_push_full, q_stat.full, !q_push, "push into full queue")

endmodule

`default_nettype wire

@@ sv/jse_front.sv @@
`default_nettype none

module jse_front
    import jse_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    jse_in_if.sink       raw,
    input  wire q_stat_t q_stat,
    output logic         push,
    output cmd_t         cmd
);

    localparam logic [7:0] LEAD2_LO = 8'hc2;
    localparam logic [7:0] LEAD2_HI = 8'hdf;
    localparam logic [7:0] LEAD3_LO = 8'he0;
    localparam logic [7:0] LEAD3_HI = 8'hef;
    localparam logic [7:0] LEAD4_LO = 8'hf0;
    localparam logic [7:0] LEAD4_HI = 8'hf4;
    localparam logic [7:0] LEAD_E0  = 8'he0;
    localparam logic [7:0] LEAD_ED  = 8'hed;
    localparam logic [7:0] LEAD_F0  = 8'hf0;
    localparam logic [7:0] LEAD_F4  = 8'hf4;

    logic [2:0][7:0] pend_reg, pend_next;
    logic [1:0]      cnt_reg, cnt_next;
    logic [2:0]      exp_reg, exp_next;
    logic            started_reg, started_next;

    logic            acc;
    logic [7:0]      b;
    tail_kind_t      f_tail;
    logic [7:0]      f_char;
    logic [2:0]      f_len;
    logic            b_fits;

    function automatic logic fits(input logic [7:0] lead, input logic [1:0] pos,
                                  input logic [7:0] v);
        logic cont;
        logic r;
        cont = (v[7:6] == 2'b10);
        r = cont;
        if (pos == 2'd1) begin
            case (lead)
                LEAD_E0: r = (v >= 8'ha0) && (v <= 8'hbf);
                LEAD_ED: r = (v >= 8'h80) && (v <= 8'h9f);
                LEAD_F0: r = (v >= 8'h90) && (v <= 8'hbf);
                LEAD_F4: r = (v >= 8'h80) && (v <= 8'h8f);
                default: r = cont;
            endcase
        end
        return r;
    endfunction

    assign raw.ready = !q_stat.full;
    assign acc = raw.valid && raw.ready;
    assign b = raw.byte_value;
    assign b_fits = fits(pend_reg[0], cnt_reg, b);

    // classify a byte taken with nothing held
    always_comb
    begin
        if ((b >= LEAD2_LO) && (b <= LEAD2_HI))
            f_len = 3'd2;
        else if ((b >= LEAD3_LO) && (b <= LEAD3_HI))
            f_len = 3'd3;
        else if ((b >= LEAD4_LO) && (b <= LEAD4_HI))
            f_len = 3'd4;
        else
            f_len = 3'd0;

        f_char = b;
        case (b)
            8'h22:   begin f_tail = TAIL_SHORT; f_char = CH_QUOTE;  end
            8'h5c:   begin f_tail = TAIL_SHORT; f_char = CH_BSLASH; end
            8'h08:   begin f_tail = TAIL_SHORT; f_char = 8'h62;     end
            8'h0c:   begin f_tail = TAIL_SHORT; f_char = 8'h66;     end
            8'h0a:   begin f_tail = TAIL_SHORT; f_char = 8'h6e;     end
            8'h0d:   begin f_tail = TAIL_SHORT; f_char = 8'h72;     end
            8'h09:   begin f_tail = TAIL_SHORT; f_char = 8'h74;     end
            default:
            begin
                if (b < 8'h20)
                    f_tail = TAIL_HEX;
                else if (b < 8'h80)
                    f_tail = TAIL_RAW;
                else if (f_len == 3'd0)
                    f_tail = TAIL_HEX;
                else
                    f_tail = TAIL_NONE;    // new lead, held
            end
        endcase
    end

    always_comb
    begin
        cmd.open     = !started_reg;
        cmd.pend_cnt = 2'd0;
        cmd.pend_raw = 1'b0;
        cmd.pend     = pend_reg;
        cmd.tail     = TAIL_NONE;
        cmd.fresh    = b;

        pend_next    = pend_reg;
        cnt_next     = cnt_reg;
        exp_next     = exp_reg;
        started_next = started_reg;

        if (acc)
        begin
            started_next = 1'b1;
            if (raw.end_of_string)
            begin
                cmd.pend_cnt = cnt_reg;
                cmd.tail     = TAIL_CLOSE;
                pend_next    = '0;
                cnt_next     = 2'd0;
                exp_next     = 3'd0;
                started_next = 1'b0;
            end
            else if ((cnt_reg != 2'd0) && (exp_reg >= 3'd2) && b_fits &&
                     (({1'b0, cnt_reg} + 3'd1) >= exp_reg))
            begin
                // sequence complete: pass it through raw
                cmd.pend_cnt = cnt_reg;
                cmd.pend_raw = 1'b1;
                cmd.tail     = TAIL_RAW;
                pend_next    = '0;
                cnt_next     = 2'd0;
                exp_next     = 3'd0;
            end
            else if ((cnt_reg != 2'd0) && (exp_reg >= 3'd2) && b_fits)
            begin
                if (cnt_reg != 2'd3)
                begin
                    pend_next[cnt_reg] = b;
                    cnt_next = cnt_reg + 2'd1;
                end
            end
            else
            begin
                // broken sequence flushes escaped, then the byte starts afresh
                if ((cnt_reg != 2'd0) && (exp_reg >= 3'd2))
                    cmd.pend_cnt = cnt_reg;
                cmd.tail  = f_tail;
                cmd.fresh = f_char;
                pend_next = '0;
                if (f_len != 3'd0)
                begin
                    pend_next[0] = b;
                    cnt_next     = 2'd1;
                    exp_next     = f_len;
                end
                else
                begin
                    cnt_next = 2'd0;
                    exp_next = 3'd0;
                end
            end
        end
    end

    assign push = acc && (cmd.open || (cmd.pend_cnt != 2'd0) || (cmd.tail != TAIL_NONE));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg    <= '0;
            cnt_reg     <= 2'd0;
            exp_reg     <= 3'd0;
            started_reg <= 1'b0;
        end
        else
        begin
            pend_reg    <= pend_next;
            cnt_reg     <= cnt_next;
            exp_reg     <= exp_next;
            started_reg <= started_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/jse_queue.sv @@
`default_nettype none

module jse_queue
    import jse_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t wr_cmd,
    input  wire logic pop,
    output cmd_t      head,
    output q_stat_t   stat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    cmd_t          mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push, do_pop;

    assign stat.full  = (count_reg == FULL_CNT);
    assign stat.empty = (count_reg == '0);
    assign do_push = push && !stat.full;
    assign do_pop  = pop && !stat.empty;
    assign head = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= wr_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + CW'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - CW'(1);
        end
    end

endmodule

`default_nettype wire

@@ sv/jse_back.sv @@
`default_nettype none

module jse_back
    import jse_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire cmd_t    head,
    input  wire q_stat_t q_stat,
    output logic         pop,
    jse_out_if.source    quoted
);

    localparam logic [1:0] PH_OPEN = 2'd0;
    localparam logic [1:0] PH_PEND = 2'd1;
    localparam logic [1:0] PH_TAIL = 2'd2;

    logic [1:0] phase_reg, phase_next, eff_phase;
    logic [1:0] idx_reg, idx_next;
    logic [2:0] sub_reg, sub_next;
    logic       ovalid_reg;
    logic [7:0] obyte_reg;
    logic       olast_reg;

    logic       step, unit_end, done, has_tail;
    logic [7:0] cur_byte, pend_byte;

    function automatic logic [7:0] hex_digit(input logic [3:0] n);
        return (n < 4'd10) ? (CH_ZERO + {4'd0, n}) : (8'h57 + {4'd0, n});
    endfunction

    // one character of a \u00xx escape
    function automatic logic [7:0] esc_char(input logic [7:0] v, input logic [2:0] s);
        logic [7:0] c;
        case (s)
            3'd0:    c = CH_BSLASH;
            3'd1:    c = CH_U;
            3'd2:    c = CH_ZERO;
            3'd3:    c = CH_ZERO;
            3'd4:    c = hex_digit(v[7:4]);
            default: c = hex_digit(v[3:0]);
        endcase
        return c;
    endfunction

    assign step      = !q_stat.empty && (!ovalid_reg || quoted.ready);
    assign has_tail  = (head.tail != TAIL_NONE);
    assign pend_byte = head.pend[idx_reg];

    // a command without an opening quote starts at its first non-empty part
    always_comb
    begin
        if ((phase_reg == PH_OPEN) && !head.open)
            eff_phase = (head.pend_cnt != 2'd0) ? PH_PEND : PH_TAIL;
        else
            eff_phase = phase_reg;
    end

    always_comb
    begin
        cur_byte = CH_QUOTE;
        unit_end = 1'b1;
        case (eff_phase)
            PH_OPEN:
            begin
                cur_byte = CH_QUOTE;
                unit_end = 1'b1;
            end
            PH_PEND:
            begin
                cur_byte = head.pend_raw ? pend_byte : esc_char(pend_byte, sub_reg);
                unit_end = head.pend_raw || (sub_reg == 3'd5);
            end
            PH_TAIL:
            begin
                case (head.tail)
                    TAIL_RAW:
                    begin
                        cur_byte = head.fresh;
                        unit_end = 1'b1;
                    end
                    TAIL_SHORT:
                    begin
                        cur_byte = (sub_reg == 3'd0) ? CH_BSLASH : head.fresh;
                        unit_end = (sub_reg == 3'd1);
                    end
                    TAIL_HEX:
                    begin
                        cur_byte = esc_char(head.fresh, sub_reg);
                        unit_end = (sub_reg == 3'd5);
                    end
                    default:
                    begin
                        cur_byte = CH_QUOTE;
                        unit_end = 1'b1;
                    end
                endcase
            end
            default:
            begin
                cur_byte = CH_QUOTE;
                unit_end = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        phase_next = eff_phase;
        idx_next   = idx_reg;
        sub_next   = sub_reg + 3'd1;
        done       = 1'b0;
        if (unit_end)
        begin
            sub_next = 3'd0;
            case (eff_phase)
                PH_OPEN:
                begin
                    if (head.pend_cnt != 2'd0)
                    begin
                        phase_next = PH_PEND;
                        idx_next   = 2'd0;
                    end
                    else if (has_tail)
                        phase_next = PH_TAIL;
                    else
                        done = 1'b1;
                end
                PH_PEND:
                begin
                    if (idx_reg == (head.pend_cnt - 2'd1))
                    begin
                        if (has_tail)
                            phase_next = PH_TAIL;
                        else
                            done = 1'b1;
                    end
                    else
                        idx_next = idx_reg + 2'd1;
                end
                default: done = 1'b1;
            endcase
            if (done)
            begin
                phase_next = PH_OPEN;
                idx_next   = 2'd0;
            end
        end
    end

    assign pop = step && done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_OPEN;
            idx_reg    <= 2'd0;
            sub_reg    <= 3'd0;
            ovalid_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            idx_reg    <= idx_next;
            sub_reg    <= sub_next;
            ovalid_reg <= 1'b1;
        end
        else if (quoted.ready)
            ovalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            obyte_reg <= cur_byte;
            olast_reg <= done;
        end
    end

    assign quoted.valid       = ovalid_reg;
    assign quoted.out_byte    = obyte_reg;
    assign quoted.last_of_run = olast_reg;

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

// Escaper bench: drives string bytes and end items into the raw channel,
// predicts the quoted text item by item and checks every output byte in order.
module testbench;
    import jse_pkg::*;

    // characters of the escaped text that the package does not name
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_B = 8'h62;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] CH_LOWER_N = 8'h6e;
    localparam logic [7:0] CH_LOWER_R = 8'h72;
    localparam logic [7:0] CH_LOWER_T = 8'h74;

    // control bytes that have a short escape
    localparam logic [7:0] BYTE_BS  = 8'h08;
    localparam logic [7:0] BYTE_TAB = 8'h09;
    localparam logic [7:0] BYTE_LF  = 8'h0a;
    localparam logic [7:0] BYTE_FF  = 8'h0c;
    localparam logic [7:0] BYTE_CR  = 8'h0d;

    localparam logic [7:0] CTRL_LIMIT  = 8'h20;  // below: control byte
    localparam logic [7:0] ASCII_LIMIT = 8'h80;  // below: plain ASCII

    // UTF-8 lead ranges and the narrowed second-byte ranges
    localparam logic [7:0] LEAD2_MIN  = 8'hc2;
    localparam logic [7:0] LEAD2_MAX  = 8'hdf;
    localparam logic [7:0] LEAD3_MIN  = 8'he0;
    localparam logic [7:0] LEAD3_MAX  = 8'hef;
    localparam logic [7:0] LEAD4_MIN  = 8'hf0;
    localparam logic [7:0] LEAD4_MAX  = 8'hf4;
    localparam logic [7:0] LEAD_ED    = 8'hed;
    localparam logic [7:0] CONT_MASK  = 8'hc0;
    localparam logic [7:0] CONT_TAG   = 8'h80;
    localparam logic [7:0] CONT_MAX   = 8'hbf;
    localparam logic [7:0] E0_MIN_2ND = 8'ha0;
    localparam logic [7:0] ED_MAX_2ND = 8'h9f;
    localparam logic [7:0] F0_MIN_2ND = 8'h90;
    localparam logic [7:0] F4_MAX_2ND = 8'h8f;

    localparam int STALL_LIMIT   = 2000;  // cycles with no item moving on either side
    localparam int RANDOM_ITEMS  = 380;   // random part with idling
    localparam int TOTAL_ITEMS   = 430;   // then full rate up to this count
    localparam int DRAIN_CYCLES  = 40;    // quiet tail after the last expected byte
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } quoted_byte_t;

    logic clk;
    logic rst_n;

    jse_in_if  raw_if();
    jse_out_if quoted_if();

    json_string_escaper_utf8 dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .raw    (raw_if),
        .quoted (quoted_if)
    );

    always #4 clk = ~clk;

    // ---------------------------------------------------------------------
    // Escaper model: own copy of the held UTF-8 bytes and the quote state.
    // ---------------------------------------------------------------------
    logic [7:0]   held_bytes [3];
    logic [1:0]   held_count;
    logic [2:0]   seq_len;      // full length of the held sequence, 0 if none
    logic         quote_open;   // opening quote already sent for this string
    logic [7:0]   run_bytes [$];
    quoted_byte_t quoted_expect [$];

    int items_sent;
    int strings_closed;
    int bytes_checked;
    int mismatch_count;
    int idle_cycles;

    // idling controls, percent chance per item / per cycle
    int gap_pct;
    int stall_pct;
    int stall_left;

    function automatic logic [7:0] hex_char(logic [3:0] d);
        return (d < 4'd10) ? CH_ZERO + {4'd0, d} : CH_LOWER_A + {4'd0, d} - 8'd10;
    endfunction

    function automatic void emit_raw(logic [7:0] b);
        run_bytes.push_back(b);
    endfunction

    function automatic void emit_pair(logic [7:0] c);
        emit_raw(CH_BSLASH);
        emit_raw(c);
    endfunction

    function automatic void emit_hex(logic [7:0] b);
        emit_raw(CH_BSLASH);
        emit_raw(CH_U);
        emit_raw(CH_ZERO);
        emit_raw(CH_ZERO);
        emit_raw(hex_char(b[7:4]));
        emit_raw(hex_char(b[3:0]));
    endfunction

    function automatic void clear_held();
        held_bytes[0] = '0;
        held_bytes[1] = '0;
        held_bytes[2] = '0;
        held_count    = '0;
        seq_len       = '0;
    endfunction

    function automatic void flush_held();
        for (int i = 0; i < int'(held_count); i++)
            emit_hex(held_bytes[i]);
        clear_held();
    endfunction

    function automatic int lead_len(logic [7:0] b);
        if (b >= LEAD2_MIN && b <= LEAD2_MAX) return 2;
        if (b >= LEAD3_MIN && b <= LEAD3_MAX) return 3;
        if (b >= LEAD4_MIN && b <= LEAD4_MAX) return 4;
        return 0;
    endfunction

    // does b fit as byte number pos (1 = second byte) after this lead
    function automatic logic fits_at(logic [7:0] lead, int pos, logic [7:0] b);
        if (pos == 1)
        begin
            if (lead == LEAD3_MIN) return b >= E0_MIN_2ND && b <= CONT_MAX;
            if (lead == LEAD_ED)   return b >= CONT_TAG && b <= ED_MAX_2ND;
            if (lead == LEAD4_MIN) return b >= F0_MIN_2ND && b <= CONT_MAX;
            if (lead == LEAD4_MAX) return b >= CONT_TAG && b <= F4_MAX_2ND;
        end
        return (b & CONT_MASK) == CONT_TAG;
    endfunction

    // byte seen with nothing held
    function automatic void take_fresh(logic [7:0] b);
        int n;
        case (b)
            CH_QUOTE:  begin emit_pair(CH_QUOTE);   return; end
            CH_BSLASH: begin emit_pair(CH_BSLASH);  return; end
            BYTE_BS:   begin emit_pair(CH_LOWER_B); return; end
            BYTE_FF:   begin emit_pair(CH_LOWER_F); return; end
            BYTE_LF:   begin emit_pair(CH_LOWER_N); return; end
            BYTE_CR:   begin emit_pair(CH_LOWER_R); return; end
            BYTE_TAB:  begin emit_pair(CH_LOWER_T); return; end
            default: ;
        endcase
        if (b < CTRL_LIMIT)
        begin
            emit_hex(b);
            return;
        end
        if (b < ASCII_LIMIT)
        begin
            emit_raw(b);
            return;
        end
        n = lead_len(b);
        if (n == 0)
        begin
            emit_hex(b);  // stray continuation or invalid lead
            return;
        end
        held_bytes[0] = b;
        held_count    = 2'd1;
        seq_len       = 3'(n);
    endfunction

    function automatic void take_string_byte(logic [7:0] b);
        if (held_count == 0 || seq_len < 2)
        begin
            clear_held();
            take_fresh(b);
            return;
        end
        if (!fits_at(held_bytes[0], int'(held_count), b))
        begin
            // broken sequence: escape what was held, then judge b on its own
            flush_held();
            take_fresh(b);
            return;
        end
        if (int'(held_count) + 1 >= int'(seq_len))
        begin
            for (int i = 0; i < int'(held_count); i++)
                emit_raw(held_bytes[i]);
            emit_raw(b);
            clear_held();
            return;
        end
        held_bytes[held_count] = b;
        held_count = held_count + 2'd1;
    endfunction

    // expected quoted bytes for one accepted raw item
    function automatic void predict_quoted(logic [7:0] b, logic eos);
        quoted_byte_t entry;
        run_bytes.delete();
        if (!quote_open)
        begin
            emit_raw(CH_QUOTE);
            quote_open = 1'b1;
        end
        if (eos)
        begin
            flush_held();
            emit_raw(CH_QUOTE);
            quote_open = 1'b0;
            strings_closed++;
        end
        else
            take_string_byte(b);
        foreach (run_bytes[i])
        begin
            entry.out_byte    = run_bytes[i];
            entry.last_of_run = (i == run_bytes.size() - 1);
            quoted_expect.push_back(entry);
        end
    endfunction

    // ---------------------------------------------------------------------
    // Raw side driver: one item per call, random gap first, data changes on
    // the falling edge, acceptance seen at the rising edge.
    // ---------------------------------------------------------------------
    task automatic send_item(input logic [7:0] b, input logic eos);
        int gap_len;
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            gap_len = $urandom_range(1, 13);
            @(negedge clk);
            raw_if.valid <= 1'b0;
            repeat (gap_len - 1) @(negedge clk);
        end
        @(negedge clk);
        raw_if.valid         <= 1'b1;
        raw_if.byte_value    <= b;
        raw_if.end_of_string <= eos;
        do
            @(posedge clk);
        while (!raw_if.ready);
        items_sent++;
        predict_quoted(b, eos);
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(b, 1'b0);
    endtask

    // end item; byte_value is don't-care, so drive it with noise
    task automatic send_end();
        send_item(8'($urandom), 1'b1);
    endtask

    function automatic logic [7:0] second_byte_for(logic [7:0] lead);
        if (lead == LEAD3_MIN) return 8'($urandom_range(E0_MIN_2ND, CONT_MAX));
        if (lead == LEAD_ED)   return 8'($urandom_range(CONT_TAG, ED_MAX_2ND));
        if (lead == LEAD4_MIN) return 8'($urandom_range(F0_MIN_2ND, CONT_MAX));
        if (lead == LEAD4_MAX) return 8'($urandom_range(CONT_TAG, F4_MAX_2ND));
        return 8'($urandom_range(CONT_TAG, CONT_MAX));
    endfunction

    // well-formed code point, encoded and sent byte by byte
    task automatic send_code_point();
        int unsigned cp;
        int unsigned edges [12] = '{'h80, 'h7ff, 'h800, 'hfff, 'hd7ff, 'he000,
                                    'hffff, 'h10000, 'h3ffff, 'h40000, 'hfffff,
                                    'h10ffff};
        if ($urandom_range(0, 3) == 0)
            cp = edges[$urandom_range(0, 11)];
        else
            case ($urandom_range(0, 4))
                0: cp = $urandom_range('h80, 'h7ff);
                1: cp = $urandom_range('h800, 'hfff);
                2: cp = $urandom_range('h1000, 'hd7ff);
                3: cp = $urandom_range('he000, 'hffff);
                default: cp = $urandom_range('h10000, 'h10ffff);
            endcase
        if (cp < 'h800)
        begin
            send_byte(8'('hc0 | (cp >> 6)));
            send_byte(8'('h80 | (cp & 'h3f)));
        end
        else if (cp < 'h10000)
        begin
            send_byte(8'('he0 | (cp >> 12)));
            send_byte(8'('h80 | ((cp >> 6) & 'h3f)));
            send_byte(8'('h80 | (cp & 'h3f)));
        end
        else
        begin
            send_byte(8'('hf0 | (cp >> 18)));
            send_byte(8'('h80 | ((cp >> 12) & 'h3f)));
            send_byte(8'('h80 | ((cp >> 6) & 'h3f)));
            send_byte(8'('h80 | (cp & 'h3f)));
        end
    endtask

    // lead plus a fitting prefix, then a byte that may break it, or an end
    task automatic send_broken_sequence();
        logic [7:0] lead;
        int         n_cont;
        lead   = 8'($urandom_range(LEAD2_MIN, LEAD4_MAX));
        n_cont = $urandom_range(0, lead_len(lead) - 2);
        send_byte(lead);
        for (int i = 0; i < n_cont; i++)
            send_byte(i == 0 ? second_byte_for(lead)
                             : 8'($urandom_range(CONT_TAG, CONT_MAX)));
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: send_byte(8'($urandom));
            5, 6, 7:       send_byte(8'($urandom_range(CONT_TAG, CONT_MAX)));
            default:       send_end();
        endcase
    endtask

    // one random piece of string text
    task automatic send_segment();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 28)
            send_byte(8'($urandom_range(CTRL_LIMIT, ASCII_LIMIT - 1)));
        else if (pick < 40)
            send_byte(8'($urandom_range(0, CTRL_LIMIT - 1)));
        else if (pick < 70)
            send_code_point();
        else if (pick < 82)
            send_broken_sequence();
        else
            send_byte(8'($urandom));
    endtask

    // ---------------------------------------------------------------------
    // Quoted side: ready drops in random bursts; each accepted output byte
    // is checked against the oldest expectation.
    // ---------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (stall_pct == 0)
            stall_left = 0;
        else if (stall_left == 0 && $urandom_range(0, 99) < stall_pct)
            stall_left = $urandom_range(1, 13);
        quoted_if.ready <= (stall_left == 0);
        if (stall_left > 0)
            stall_left--;
    end

    always @(posedge clk)
    begin : check_quoted
        quoted_byte_t want;
        if (rst_n && quoted_if.valid && quoted_if.ready)
        begin
            bytes_checked++;
            if (quoted_expect.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected output byte %h last %b, nothing pending",
                             quoted_if.out_byte, quoted_if.last_of_run);
            end
            else
            begin
                want = quoted_expect.pop_front();
                if (quoted_if.out_byte !== want.out_byte
                    || quoted_if.last_of_run !== want.last_of_run)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("output %0d: expected byte %h last %b, got byte %h last %b",
                                 bytes_checked, want.out_byte, want.last_of_run,
                                 quoted_if.out_byte, quoted_if.last_of_run);
                end
            end
        end
    end

    // hang detection: no item moving on either channel for too long
    always @(posedge clk)
    begin
        if (!rst_n || (raw_if.valid && raw_if.ready)
            || (quoted_if.valid && quoted_if.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: %0d cycles without progress, %0d bytes still expected",
                     idle_cycles, quoted_expect.size());
            $display("testbench: FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // empty string first (opening quote on an end item), then every short
    // escape, the control range ends and a zero byte
    task automatic test_empty_and_escapes();
        logic [7:0] list [9] = '{8'h00, 8'h1f, CH_QUOTE, CH_BSLASH, BYTE_BS,
                                 BYTE_FF, BYTE_LF, BYTE_CR, BYTE_TAB};
        send_end();
        foreach (list[i])
            send_byte(list[i]);
    endtask

    // narrowed second-byte ranges, stray bytes, held bytes flushed by an
    // end item, and the longest run: three held bytes broken by a zero byte
    task automatic test_utf8_edges();
        send_byte(LEAD2_MIN);
        send_byte(CONT_TAG);
        send_byte(LEAD3_MIN);       // E0 needs A0..BF
        send_byte(ED_MAX_2ND);
        send_byte(LEAD_ED);         // ED needs 80..9F
        send_byte(E0_MIN_2ND);
        send_byte(LEAD4_MAX);       // F4 needs 80..8F
        send_byte(F0_MIN_2ND);
        send_byte(8'hc1);           // invalid lead, then stray continuation
        send_byte(CONT_TAG);
        send_byte(8'he1);
        send_byte(CONT_TAG);
        send_end();                 // flushes two held bytes
        send_byte(LEAD4_MIN);
        send_byte(F0_MIN_2ND);
        send_byte(CONT_TAG);
        send_byte(8'h00);           // breaks three held bytes
        send_end();
    endtask

    // random strings with random idling on both sides
    task automatic test_random_text();
        int pct_choice [3] = '{0, 10, 35};
        int n_seg;
        while (items_sent < RANDOM_ITEMS)
        begin
            gap_pct   = pct_choice[$urandom_range(0, 2)];
            stall_pct = pct_choice[$urandom_range(0, 2)];
            n_seg     = $urandom_range(1, 14);
            for (int i = 0; i < n_seg; i++)
                send_segment();
            send_end();
        end
    endtask

    // closing stretch with no idling at all
    task automatic test_full_rate();
        gap_pct   = 0;
        stall_pct = 0;
        while (items_sent < TOTAL_ITEMS)
            send_segment();
        send_end();
        @(negedge clk);
        raw_if.valid <= 1'b0;
    endtask

    initial
    begin
        clk                  = 1'b0;
        rst_n                = 1'b0;
        raw_if.valid         = 1'b0;
        raw_if.byte_value    = '0;
        raw_if.end_of_string = 1'b0;
        quoted_if.ready      = 1'b0;
        items_sent           = 0;
        strings_closed       = 0;
        bytes_checked        = 0;
        mismatch_count       = 0;
        idle_cycles          = 0;
        gap_pct              = 15;
        stall_pct            = 15;
        stall_left           = 0;
        quote_open           = 1'b0;
        clear_held();

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_and_escapes();
        test_utf8_edges();
        test_random_text();
        test_full_rate();

        // drain; the watchdog bounds this wait
        while (quoted_expect.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d raw items over %0d strings, %0d quoted bytes checked",
                 items_sent, strings_closed, bytes_checked);
        $display("%0d mismatches", mismatch_count);
        if (mismatch_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
